FILE: sv/brl_pkg.sv
package brl_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  // Operation codes carried by the opcode field
  typedef enum logic [2:0] {
    OP_PUSH_BACK   = 3'd0,
    OP_PUSH_FRONT  = 3'd1,
    OP_INSERT_ORD  = 3'd2,
    OP_REMOVE_BACK = 3'd3,
    OP_REMOVE_FRNT = 3'd4,
    OP_REMOVE_KEY  = 3'd5
  } op_t;

  // How a cell raises its position flag during the compare cycle
  typedef enum logic [1:0] {
    MK_ALL  = 2'd0,  // every cell
    MK_FREE = 2'd1,  // cells at or beyond the occupancy
    MK_GE   = 2'd2,  // key not smaller than the operand, or unoccupied
    MK_EQ   = 2'd3   // occupied and key equal to the operand
  } mark_t;

  // What a cell does in the update cycle
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } act_t;

  typedef struct packed {
    mark_t mark;
    act_t  act;
    logic  flag_en;
    logic  upd_en;
  } cell_ctrl_t;

endpackage

FILE: sv/bounded_record_list.sv
// Each operation passes through the compare and update states before its result is registered.
// The row of cells serves one operation at a time; a new one is taken only when the last is done,
// and the update waits while a previous result is still held at the output.
// All cells compare together in the compare state and shift one place in the update state.
// Reset clears the count, sequencer, result valid and cell flags; stored records are not cleared.
module bounded_record_list #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [2:0]                        opcode,
  input  logic [brl_pkg::KEY_W-1:0]         key,
  input  logic [PAYLOAD_WIDTH-1:0]          payload,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              success,
  output logic [brl_pkg::COUNT_W-1:0]       entry_count,
  output logic                              is_full,
  output logic                              is_empty
);
  import brl_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam logic [OCC_W-1:0] CAP = OCC_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t                   state;
  op_t                      op_q;
  logic [KEY_W-1:0]         key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic [OCC_W-1:0]         occ;
  logic [OCC_W-1:0]         occ_next;
  logic                     ok;
  act_t                     act;
  mark_t                    mark;
  logic                     slot_free;
  logic                     commit;
  cell_ctrl_t               ctrl;

  logic [CAPACITY-1:0]      flags;
  logic [CAPACITY-1:0]      prior;
  logic                     any_flag;
  logic [KEY_W-1:0]         cell_key [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] cell_pay [CAPACITY];

  assign item_stall = state != S_IDLE;
  assign slot_free  = !result_valid || !result_stall;
  assign commit     = (state == S_UPD) && slot_free;

  // Decode the flag rule for the held operation
  always_comb begin
    unique case (op_q)
      OP_PUSH_BACK:  mark = MK_FREE;
      OP_INSERT_ORD: mark = MK_GE;
      OP_REMOVE_KEY: mark = MK_EQ;
      default:       mark = MK_ALL;
    endcase
  end

  // Decide outcome, new count and cell action
  always_comb begin
    ok       = 1'b0;
    act      = ACT_HOLD;
    occ_next = occ;
    unique case (op_q)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_ORD: begin
        if (occ < CAP) begin
          ok       = 1'b1;
          act      = ACT_INSERT;
          occ_next = occ + OCC_W'(1);
        end
      end
      OP_REMOVE_BACK: begin
        if (occ != '0) begin
          ok       = 1'b1;
          occ_next = occ - OCC_W'(1);
        end
      end
      OP_REMOVE_FRNT: begin
        if (occ != '0) begin
          ok       = 1'b1;
          act      = ACT_REMOVE;
          occ_next = occ - OCC_W'(1);
        end
      end
      OP_REMOVE_KEY: begin
        if (any_flag) begin
          ok       = 1'b1;
          act      = ACT_REMOVE;
          occ_next = occ - OCC_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl.mark    = mark;
    ctrl.act     = act;
    ctrl.flag_en = state == S_CMP;
    ctrl.upd_en  = commit;
  end

  // Sequencer, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      occ          <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (commit) begin
        occ          <= occ_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Capture the operation on transfer
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      op_q  <= op_t'(opcode);
      key_q <= key;
      pay_q <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      success     <= ok;
      entry_count <= COUNT_W'(occ_next);
      is_full     <= occ_next == CAP;
      is_empty    <= occ_next == '0;
    end
  end

  // Row of record cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0]         lk;
    logic [PAYLOAD_WIDTH-1:0] lp;
    logic [KEY_W-1:0]         rk;
    logic [PAYLOAD_WIDTH-1:0] rp;

    if (i == 0) begin : g_first
      assign lk = key_q;
      assign lp = pay_q;
    end else begin : g_mid_l
      assign lk = cell_key[i-1];
      assign lp = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rp = '0;
    end else begin : g_mid_r
      assign rk = cell_key[i+1];
      assign rp = cell_pay[i+1];
    end

    brl_cell #(
      .INDEX (i),
      .OCC_W (OCC_W),
      .PW    (PAYLOAD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .occ       (occ),
      .new_key   (key_q),
      .new_pay   (pay_q),
      .left_key  (lk),
      .left_pay  (lp),
      .right_key (rk),
      .right_pay (rp),
      .prior     (prior[i]),
      .flag      (flags[i]),
      .key       (cell_key[i]),
      .pay       (cell_pay[i])
    );
  end

  brl_prefix #(
    .N (CAPACITY)
  ) u_prefix (
    .flags  (flags),
    .prior  (prior),
    .any    (any_flag)
  );

  // Count never passes capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= CAP)
    else $error("occupancy above capacity");

  // Count moves by at most one per operation
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && occ != $past(occ) |->
      (occ == $past(occ) + OCC_W'(1)) || (occ + OCC_W'(1) == $past(occ)))
    else $error("occupancy jumped");

  // A fresh result only follows the update cycle
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(result_valid) |-> $past(state) == S_UPD)
    else $error("result without update");

  // Full and empty exclude each other
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(is_full && is_empty))
    else $error("full and empty together");

endmodule

FILE: sv/brl_cell.sv
module brl_cell #(
  parameter int INDEX = 0,
  parameter int OCC_W = 7,
  parameter int PW    = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  brl_pkg::cell_ctrl_t        ctrl,
  input  logic [OCC_W-1:0]           occ,
  input  logic [brl_pkg::KEY_W-1:0]  new_key,
  input  logic [PW-1:0]              new_pay,
  input  logic [brl_pkg::KEY_W-1:0]  left_key,
  input  logic [PW-1:0]              left_pay,
  input  logic [brl_pkg::KEY_W-1:0]  right_key,
  input  logic [PW-1:0]              right_pay,
  input  logic                       prior,
  output logic                       flag,
  output logic [brl_pkg::KEY_W-1:0]  key,
  output logic [PW-1:0]              pay
);
  import brl_pkg::*;

  localparam logic [OCC_W-1:0] IDX = OCC_W'(INDEX);

  logic below;
  logic ge;
  logic eq;
  logic flag_next;

  // Compare own record against the broadcast operand
  assign below = IDX < occ;
  assign ge    = $signed(key) >= $signed(new_key);
  assign eq    = key == new_key;

  always_comb begin
    unique case (ctrl.mark)
      MK_ALL:  flag_next = 1'b1;
      MK_FREE: flag_next = !below;
      MK_GE:   flag_next = !below || ge;
      MK_EQ:   flag_next = below && eq;
      default: flag_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.flag_en) begin
      flag <= flag_next;
    end
  end

  // Shift toward the back on insert, toward the front on remove
  always_ff @(posedge clk) begin
    if (ctrl.upd_en) begin
      unique case (ctrl.act)
        ACT_INSERT: begin
          if (prior) begin
            key <= left_key;
            pay <= left_pay;
          end else if (flag) begin
            key <= new_key;
            pay <= new_pay;
          end
        end
        ACT_REMOVE: begin
          if (prior || flag) begin
            key <= right_key;
            pay <= right_pay;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/brl_prefix.sv
module brl_prefix #(
  parameter int N = 64
) (
  input  logic [N-1:0] flags,
  output logic [N-1:0] prior,
  output logic         any
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 0;

  logic [N-1:0] lvl [LEVELS+1];

  assign lvl[0] = flags;

  // Parallel prefix OR, doubling the span at each level
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  // Exclusive prefix: a flag somewhere strictly in front of this cell
  assign prior[0] = 1'b0;
  for (genvar i = 1; i < N; i++) begin : g_excl
    assign prior[i] = lvl[LEVELS][i-1];
  end

  assign any = lvl[LEVELS][N-1];

endmodule

FILE: tb/bounded_record_list_checker.sv
module bounded_record_list_checker #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        item_stall,
  input  logic [2:0]                  opcode,
  input  logic [brl_pkg::KEY_W-1:0]   key,
  input  logic [PAYLOAD_WIDTH-1:0]    payload,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  logic                        success,
  input  logic [brl_pkg::COUNT_W-1:0] entry_count,
  input  logic                        is_full,
  input  logic                        is_empty,
  output int                          error_count,
  output int                          outstanding,
  output int                          results_checked,
  output int                          full_refusals
);

  import brl_pkg::*;

  typedef struct packed {
    logic               success;
    logic [COUNT_W-1:0] count;
    logic               full;
    logic               empty;
  } list_status_t;

  // Shadow copy of the record list
  logic [KEY_W-1:0]         rec_key     [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] rec_payload [CAPACITY];
  int unsigned              held = 0;

  list_status_t status_due [$];
  int mismatches = 0;
  int checked    = 0;
  int refusals   = 0;

  // Apply one operation to the shadow list and return the status it reports
  function automatic list_status_t apply_to_list(input logic [2:0] op,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [PAYLOAD_WIDTH-1:0] p);
    list_status_t st;
    int unsigned  pos;
    int unsigned  j;
    logic         ok;
    logic         is_push;
    logic         is_remove;
    ok        = 1'b0;
    is_push   = 1'b0;
    is_remove = 1'b0;
    pos       = 0;
    case (op)
      OP_PUSH_BACK: begin
        is_push = 1'b1;
        pos     = held;
      end
      OP_PUSH_FRONT: is_push = 1'b1;
      OP_INSERT_ORD: begin
        is_push = 1'b1;
        // Stop at the first key that is not smaller, so the new record lands ahead of equal keys
        while (pos < held && $signed(rec_key[pos]) < $signed(k)) pos++;
      end
      OP_REMOVE_BACK: begin
        is_remove = (held > 0);
        pos       = (held > 0) ? held - 1 : 0;
      end
      OP_REMOVE_FRNT: is_remove = (held > 0);
      OP_REMOVE_KEY: begin
        while (pos < held && rec_key[pos] != k) pos++;
        is_remove = (pos < held);
      end
      default: ;
    endcase

    // Open a gap and drop the new record into it
    if (is_push) begin
      if (held < CAPACITY) begin
        for (j = held; j > pos; j--) begin
          rec_key[j]     = rec_key[j-1];
          rec_payload[j] = rec_payload[j-1];
        end
        rec_key[pos]     = k;
        rec_payload[pos] = p;
        held++;
        ok = 1'b1;
      end else begin
        refusals++;
      end
    end

    // Close the gap left by the removed record
    if (is_remove) begin
      for (j = pos; j + 1 < held; j++) begin
        rec_key[j]     = rec_key[j+1];
        rec_payload[j] = rec_payload[j+1];
      end
      held--;
      ok = 1'b1;
    end

    st.success = ok;
    st.count   = COUNT_W'(held);
    st.full    = (held == CAPACITY);
    st.empty   = (held == 0);
    return st;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Check each result transfer first, then predict for each item transfer
  always @(posedge clk) begin : watch
    list_status_t want;
    if (rst) begin
      held = 0;
      status_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing actual count %0d",
                   $time, entry_count);
        end else begin
          want = status_due.pop_front();
          checked++;
          compare_field("success", want.success, success);
          compare_field("entry_count", want.count, entry_count);
          compare_field("is_full", want.full, is_full);
          compare_field("is_empty", want.empty, is_empty);
        end
      end
      if (item_valid && !item_stall)
        status_due.push_back(apply_to_list(opcode, key, payload));
    end
    error_count     <= mismatches;
    outstanding     <= status_due.size();
    results_checked <= checked;
    full_refusals   <= refusals;
  end

endmodule

FILE: tb/bounded_record_list_tb.sv
module bounded_record_list_tb;

  import brl_pkg::*;

  localparam int CAPACITY      = 64;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int RANDOM_ITEMS  = 600;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;

  // Opcodes the block must ignore
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_SORTED, MIX_ANY} op_mix_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     item_valid   = 1'b0;
  logic [2:0]               opcode       = OP_PUSH_BACK;
  logic [KEY_W-1:0]         key          = '0;
  logic [PAYLOAD_WIDTH-1:0] payload      = '0;
  logic                     result_stall = 1'b0;
  logic                     item_stall;
  logic                     result_valid;
  logic                     success;
  logic [COUNT_W-1:0]       entry_count;
  logic                     is_full;
  logic                     is_empty;

  int error_count;
  int outstanding;
  int results_checked;
  int full_refusals;

  int items_sent    = 0;
  int burst_left    = 0;
  bit steady_sender = 1'b0;
  int cycle_count   = 0;
  int stall_style   = 0;
  int style_left    = 0;
  int hold_left     = 0;

  bounded_record_list #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .key          (key),
    .payload      (payload),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .success      (success),
    .entry_count  (entry_count),
    .is_full      (is_full),
    .is_empty     (is_empty)
  );

  bounded_record_list_checker #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .opcode          (opcode),
    .key             (key),
    .payload         (payload),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .success         (success),
    .entry_count     (entry_count),
    .is_full         (is_full),
    .is_empty        (is_empty),
    .error_count     (error_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_refusals   (full_refusals)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("bounded_record_list test failed");
      $finish;
    end
  end

  // Receiver: switch between no stall, light, heavy and long-hold stall styles
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(50, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 9) < 3);
        2: result_stall <= ($urandom_range(0, 9) < 7);
        default: begin
          if (hold_left == 0) begin
            result_stall <= ~result_stall;
            hold_left    <= $urandom_range(1, 20);
          end else begin
            hold_left <= hold_left - 1;
          end
        end
      endcase
    end
  end

  function automatic logic [2:0] push_op();
    case ($urandom_range(0, 2))
      0:       return OP_PUSH_BACK;
      1:       return OP_PUSH_FRONT;
      default: return OP_INSERT_ORD;
    endcase
  endfunction

  function automatic logic [2:0] remove_op();
    case ($urandom_range(0, 2))
      0:       return OP_REMOVE_BACK;
      1:       return OP_REMOVE_FRNT;
      default: return OP_REMOVE_KEY;
    endcase
  endfunction

  function automatic logic [2:0] unused_op();
    return $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
  endfunction

  function automatic logic [2:0] pick_op(input op_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (roll < 92) ? push_op() : ((roll < 97) ? remove_op() : unused_op());
      MIX_DRAIN: return (roll < 92) ? remove_op() : ((roll < 97) ? push_op() : unused_op());
      MIX_SORTED: begin
        // Keep the list ordered: insert by key, take out by key, from the front or from the back
        if (roll < 50)      return OP_INSERT_ORD;
        else if (roll < 85) return OP_REMOVE_KEY;
        else if (roll < 95) return OP_REMOVE_FRNT;
        else                return OP_REMOVE_BACK;
      end
      default:   return (roll < 45) ? push_op() : ((roll < 90) ? remove_op() : unused_op());
    endcase
  endfunction

  // Mostly a small pool of keys so duplicates and key hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) >= 7) return $urandom();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h0000_0005;
      6:       return 32'hFFFF_FFFB;
      default: return 32'h0000_0064;
    endcase
  endfunction

  // Send one item; start a new burst after a random gap when the current one runs out
  task automatic send(input logic [2:0] op, input logic [KEY_W-1:0] k,
                      input logic [PAYLOAD_WIDTH-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item_valid <= 1'b1;
    opcode     <= op;
    key        <= k;
    payload    <= p;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic run_segment(input op_mix_t mix, input int count);
    steady_sender = ($urandom_range(0, 3) == 0);
    repeat (count) send(pick_op(mix), pick_key(), $urandom());
  endtask

  initial begin
    int random_start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Refusals and ignored opcodes on an empty list
    send(OP_REMOVE_BACK, 32'h0000_0000, 32'h0000_0000);
    send(OP_REMOVE_FRNT, 32'h0000_0000, 32'h0000_0000);
    send(OP_REMOVE_KEY,  32'h0000_0000, 32'h0000_0000);
    send(OP_UNUSED_6,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_UNUSED_7,    32'h8000_0000, 32'h0000_0000);
    // Key and payload extremes, ordered inserts with duplicates at both ends
    send(OP_PUSH_BACK,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send(OP_PUSH_FRONT,  32'h8000_0000, 32'h0000_0000);
    send(OP_INSERT_ORD,  32'h0000_0000, 32'hA5A5_A5A5);
    send(OP_INSERT_ORD,  32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send(OP_INSERT_ORD,  32'h0000_0000, 32'h0000_0001);
    send(OP_INSERT_ORD,  32'h7FFF_FFFF, 32'h0000_0002);
    send(OP_INSERT_ORD,  32'h8000_0000, 32'h0000_0003);
    // Absent key, first of duplicates, ignored opcode on a non-empty list
    send(OP_REMOVE_KEY,  32'h0000_3039, 32'h0000_0000);
    send(OP_REMOVE_KEY,  32'h0000_0000, 32'h0000_0000);
    send(OP_UNUSED_6,    32'h0000_0000, 32'h0000_0000);
    send(OP_REMOVE_KEY,  32'h8000_0000, 32'h0000_0000);
    send(OP_REMOVE_FRNT, 32'h0000_0000, 32'h0000_0000);
    send(OP_REMOVE_BACK, 32'h0000_0000, 32'h0000_0000);
    send(OP_PUSH_BACK,   $urandom(),    $urandom());
    send(OP_REMOVE_KEY,  32'h0000_0000, 32'h0000_0000);
    // Drain to empty and refuse once more
    repeat (4) send(OP_REMOVE_BACK, 32'h0000_0000, 32'h0000_0000);

    // Fill past capacity, drain past empty, then random traffic mixes
    random_start = items_sent;
    run_segment(MIX_FILL, 90);
    run_segment(MIX_DRAIN, 90);
    while (items_sent - random_start < RANDOM_ITEMS)
      run_segment(op_mix_t'($urandom_range(0, 3)), $urandom_range(20, 80));
    item_valid <= 1'b0;

    // Wait for the last results, then let the bench settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d list operations over all opcodes; %0d results compared,",
             items_sent, results_checked);
    $display("%0d pushes refused on a full list.", full_refusals);
    if (error_count == 0)
      $display("bounded_record_list test passed");
    else
      $display("bounded_record_list test failed");
    $finish;
  end

endmodule
